FILE: hdl/alsr_pkg.sv
package alsr_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_COLOR_WORD = 3'd0;
  localparam logic [2:0] REG_ONE_HIGH   = 3'd1;
  localparam logic [2:0] REG_ZERO_HIGH  = 3'd2;
  localparam logic [2:0] REG_ONE_LOW    = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW   = 3'd4;

  // input commands
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  localparam int unsigned WordBits = 24;
  localparam int unsigned TimeBits = 10;
  localparam int unsigned PosBits  = 5;
  localparam logic [PosBits-1:0] LastBitPos = PosBits'(WordBits - 1);

  // one result beat
  typedef struct packed {
    logic line_zero;
    logic line_one;
    logic busy_res;
    logic done_res;
    logic start_refused;
  } result_t;

  // a phase length of zero is treated as a length of one
  function automatic logic [TimeBits-1:0] phase_len(input logic [TimeBits-1:0] v);
    phase_len = (v == '0) ? TimeBits'(1) : v;
  endfunction

endpackage

FILE: hdl/addressable_led_serializer.sv
// channel  | signals                                  | direction
// config   | psel/penable/pwrite/paddr/pwdata/prdata  | apb slave, pready tied high
// input    | in_valid_i/in_ready_o + 3 fields         | command beat in
// output   | out_valid_o/out_ready_i + 5 fields       | one result beat per input beat
//
// every input beat is worked combinationally and its result is registered; one
// beat a cycle is sustained, limited only by the output register pair.
// a two-entry output stage (main + skid) keeps in_ready_o from a register, so a
// new beat is taken while one finished result still waits.
// reset clears the transfer state and the output stage; registers take their
// documented defaults.
module addressable_led_serializer
  import alsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input beats
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic        channel_i,
  input  logic [7:0]  led_count_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_zero_o,
  output logic        line_one_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        start_refused_o
);

  // configuration registers
  logic [WordBits-1:0] color_q;
  logic [TimeBits-1:0] one_high_q, zero_high_q, one_low_q, zero_low_q;
  logic [2:0]          reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= 24'h00FF00;
      one_high_q  <= 10'd80;
      zero_high_q <= 10'd40;
      one_low_q   <= 10'd45;
      zero_low_q  <= 10'd85;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COLOR_WORD: color_q     <= pwdata[WordBits-1:0];
        REG_ONE_HIGH:   one_high_q  <= pwdata[TimeBits-1:0];
        REG_ZERO_HIGH:  zero_high_q <= pwdata[TimeBits-1:0];
        REG_ONE_LOW:    one_low_q   <= pwdata[TimeBits-1:0];
        REG_ZERO_LOW:   zero_low_q  <= pwdata[TimeBits-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_COLOR_WORD: prdata = {8'd0, color_q};
      REG_ONE_HIGH:   prdata = {22'd0, one_high_q};
      REG_ZERO_HIGH:  prdata = {22'd0, zero_high_q};
      REG_ONE_LOW:    prdata = {22'd0, one_low_q};
      REG_ZERO_LOW:   prdata = {22'd0, zero_low_q};
      default:        prdata = '0;
    endcase
  end

  // transfer state
  logic                active_q, active_d;
  logic                target_q, target_d;
  logic [7:0]          leds_left_q, leds_left_d;
  logic [PosBits-1:0]  bit_pos_q, bit_pos_d;
  logic                high_q, high_d;
  logic [TimeBits-1:0] timer_q, timer_d;
  logic [WordBits-1:0] shift_q, shift_d;

  logic    in_acc;
  result_t res;
  logic    level;
  logic    line_sel;
  logic    cur_bit;

  assign in_acc  = in_valid_i && in_ready_o;
  assign cur_bit = shift_q[WordBits-1];

  // one beat of work: start, refusal or one waveform cycle
  always_comb begin
    active_d    = active_q;
    target_d    = target_q;
    leds_left_d = leds_left_q;
    bit_pos_d   = bit_pos_q;
    high_d      = high_q;
    timer_d     = timer_q;
    shift_d     = shift_q;
    res         = '0;
    level       = active_q && high_q;
    line_sel    = target_q;
    res.busy_res = active_q;

    if (command_i == CMD_START) begin
      if (active_q) begin
        res.start_refused = 1'b1;
      end else begin
        // load a new transfer; the first high phase shows at once
        active_d    = 1'b1;
        target_d    = channel_i;
        leds_left_d = led_count_i;
        shift_d     = color_q;
        bit_pos_d   = '0;
        high_d      = 1'b1;
        timer_d     = phase_len(color_q[WordBits-1] ? one_high_q : zero_high_q);
        level       = 1'b1;
        line_sel    = channel_i;
        res.busy_res = 1'b1;
      end
    end else if (active_q) begin
      if (timer_q > TimeBits'(1)) begin
        timer_d = timer_q - TimeBits'(1);
      end else if (high_q) begin
        // high phase over, start low phase of the same bit
        high_d  = 1'b0;
        timer_d = phase_len(cur_bit ? one_low_q : zero_low_q);
      end else if (bit_pos_q < LastBitPos) begin
        // next bit of the same word
        bit_pos_d = bit_pos_q + PosBits'(1);
        shift_d   = {shift_q[WordBits-2:0], 1'b0};
        high_d    = 1'b1;
        timer_d   = phase_len(shift_q[WordBits-2] ? one_high_q : zero_high_q);
      end else if (leds_left_q != '0) begin
        // next word
        leds_left_d = leds_left_q - 8'd1;
        shift_d     = color_q;
        bit_pos_d   = '0;
        high_d      = 1'b1;
        timer_d     = phase_len(color_q[WordBits-1] ? one_high_q : zero_high_q);
      end else begin
        // last low phase ends the transfer
        active_d     = 1'b0;
        high_d       = 1'b0;
        timer_d      = '0;
        bit_pos_d    = '0;
        res.done_res = 1'b1;
      end
    end

    res.line_zero = !line_sel && level;
    res.line_one  = line_sel && level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      target_q    <= 1'b0;
      leds_left_q <= '0;
      bit_pos_q   <= '0;
      high_q      <= 1'b0;
      timer_q     <= '0;
      shift_q     <= '0;
    end else if (in_acc) begin
      active_q    <= active_d;
      target_q    <= target_d;
      leds_left_q <= leds_left_d;
      bit_pos_q   <= bit_pos_d;
      high_q      <= high_d;
      timer_q     <= timer_d;
      shift_q     <= shift_d;
    end
  end

  // output stage: main register plus skid register
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  assign in_ready_o = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_acc;
        out_d       = res;
      end
    end else if (in_acc) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o     = out_valid_q;
  assign line_zero_o     = out_q.line_zero;
  assign line_one_o      = out_q.line_one;
  assign busy_res_o      = out_q.busy_res;
  assign done_res_o      = out_q.done_res;
  assign start_refused_o = out_q.start_refused;

  // checks
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while main register is empty");

  a_done_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o)
    else $error("done reported without busy");

  a_one_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(line_zero_o && line_one_o))
    else $error("both lines driven high");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res.done_res |=> !active_q)
    else $error("transfer still active after done");

endmodule
